// File: sv/bmprb_pkg.sv
package bmprb_pkg;

   // Field and register widths.
   localparam int DIM_W       = 13;
   localparam int PITCH_W     = 15;
   localparam int BYTE_W      = 8;
   localparam int ROWB_W      = 15;
   localparam int OFFSET_W    = 26;
   localparam int COLOR_W     = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 15;

   // Default clamp limits for the image size.
   localparam int DEF_MAX_WIDTH  = 4096;
   localparam int DEF_MAX_HEIGHT = 4096;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH      = 3'd0,
      CSR_IMAGE_HEIGHT     = 3'd1,
      CSR_BOTTOM_UP        = 3'd2,
      CSR_FOUR_BYTE_PIXELS = 3'd3,
      CSR_SCREEN_WIDTH     = 3'd4,
      CSR_SCREEN_HEIGHT    = 3'd5,
      CSR_SCREEN_PITCH     = 3'd6
   } csr_index_type;

   // Reset values of the configuration registers.
   localparam logic [DIM_W-1:0]   RST_IMAGE_WIDTH   = 13'd1;
   localparam logic [DIM_W-1:0]   RST_IMAGE_HEIGHT  = 13'd1;
   localparam logic               RST_BOTTOM_UP     = 1'b1;
   localparam logic               RST_FOUR_BYTE     = 1'b0;
   localparam logic [DIM_W-1:0]   RST_SCREEN_WIDTH  = 13'd1024;
   localparam logic [DIM_W-1:0]   RST_SCREEN_HEIGHT = 13'd768;
   localparam logic [PITCH_W-1:0] RST_SCREEN_PITCH  = 15'd4096;

   localparam logic [BYTE_W-1:0]  OPAQUE_ALPHA = 8'hFF;

   // Current configuration as seen by the scan logic.
   typedef struct packed {
      logic [DIM_W-1:0]   image_width;
      logic [DIM_W-1:0]   image_height;
      logic               bottom_up;
      logic               four_byte_pixels;
      logic [DIM_W-1:0]   screen_width;
      logic [DIM_W-1:0]   screen_height;
      logic [PITCH_W-1:0] screen_pitch;
   } cfg_type;

   // A visible pixel on its way to the address stage.
   typedef struct packed {
      logic [DIM_W-1:0]   sx;
      logic [DIM_W-1:0]   sy;
      logic [COLOR_W-1:0] color;
   } pixel_type;

endpackage

// File: sv/bmp_row_blit_to_framebuffer.sv
// Streams the pixel array of an uncompressed 24- or 32-bit BMP into framebuffer
// writes. Each request beat carries one byte of the array, row padding
// included; start_of_image marks the first byte of a new image and restarts
// all counters. Each response beat carries the byte offset and the ARGB color
// of one pixel that lands on the screen; clipped pixels and padding bytes give
// no response.
// Configuration registers are written through the csr_ port; the user must write
// them only while the block is idle, which the block itself does not enforce.
// The image is centered on the screen and flipped when bottom_up is set.
// The block takes one byte per cycle while req_stall is low. Stage one captures
// the scan result at the edge that takes the byte completing a pixel, and the
// response register then captures the offset from the multiply (row times pitch).
// When rsp_stall is high the response register holds, and the stage behind it
// fills and then holds; req_stall rises only once both are full, so one
// stalled response does not stop the byte stream.
// Reset returns every configuration register to its default, clears the counters
// and empties the pipeline; no clearing pass is needed.
module bmp_row_blit_to_framebuffer
   import bmprb_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [BYTE_W-1:0]      req_pixel_byte,
   input  logic                   req_start_of_image,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [OFFSET_W-1:0]    rsp_fb_byte_offset,
   output logic [COLOR_W-1:0]     rsp_argb_color
);

   cfg_type   cfg_ff;
   logic      accept;
   logic      hit;
   pixel_type pix;

   logic      s1_valid_ff;
   pixel_type s1_pix_ff;
   logic      out_valid_ff;
   logic [OFFSET_W-1:0] out_offset_ff, out_offset_in;
   logic [COLOR_W-1:0]  out_color_ff;
   logic      out_free;
   logic      s1_free;
   logic [DIM_W+PITCH_W-1:0] row_base;

   // Configuration register file.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width      <= RST_IMAGE_WIDTH;
         cfg_ff.image_height     <= RST_IMAGE_HEIGHT;
         cfg_ff.bottom_up        <= RST_BOTTOM_UP;
         cfg_ff.four_byte_pixels <= RST_FOUR_BYTE;
         cfg_ff.screen_width     <= RST_SCREEN_WIDTH;
         cfg_ff.screen_height    <= RST_SCREEN_HEIGHT;
         cfg_ff.screen_pitch     <= RST_SCREEN_PITCH;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:      cfg_ff.image_width      <= csr_wdata[DIM_W-1:0];
            CSR_IMAGE_HEIGHT:     cfg_ff.image_height     <= csr_wdata[DIM_W-1:0];
            CSR_BOTTOM_UP:        cfg_ff.bottom_up        <= csr_wdata[0];
            CSR_FOUR_BYTE_PIXELS: cfg_ff.four_byte_pixels <= csr_wdata[0];
            CSR_SCREEN_WIDTH:     cfg_ff.screen_width     <= csr_wdata[DIM_W-1:0];
            CSR_SCREEN_HEIGHT:    cfg_ff.screen_height    <= csr_wdata[DIM_W-1:0];
            CSR_SCREEN_PITCH:     cfg_ff.screen_pitch     <= csr_wdata[PITCH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Flow control: each stage moves when the one ahead of it is free.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign s1_free   = !s1_valid_ff || out_free;
   assign req_stall = !s1_free;
   assign accept    = req_valid && s1_free;

   bmprb_scan #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_scan (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .pixel_byte     (req_pixel_byte),
      .start_of_image (req_start_of_image),
      .cfg            (cfg_ff),
      .hit            (hit),
      .pix            (pix)
   );

   // Stage one holds the screen position and color of a visible pixel.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= accept && hit;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free) begin
         s1_pix_ff <= pix;
      end
   end

   // Framebuffer offset: row times pitch plus column times four, wrapped.
   assign row_base      = s1_pix_ff.sy * cfg_ff.screen_pitch;
   assign out_offset_in = row_base[OFFSET_W-1:0]
                        + OFFSET_W'({s1_pix_ff.sx, 2'b00});

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_offset_ff <= out_offset_in;
         out_color_ff  <= s1_pix_ff.color;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_fb_byte_offset = out_offset_ff;
   assign rsp_argb_color     = out_color_ff;

endmodule

// File: sv/bmprb_scan.sv
module bmprb_scan
   import bmprb_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [BYTE_W-1:0] pixel_byte,
   input  logic              start_of_image,
   input  cfg_type           cfg,
   output logic              hit,
   output pixel_type         pix
);

   localparam logic [DIM_W:0] MAX_W_EXT = (DIM_W+1)'(MAX_WIDTH);
   localparam logic [DIM_W:0] MAX_H_EXT = (DIM_W+1)'(MAX_HEIGHT);

   // Scan counters and the partly assembled pixel.
   logic [1:0]        bip_ff, bip_in;
   logic [23:0]       asm_ff, asm_in;
   logic [DIM_W-1:0]  col_ff, col_in;
   logic [DIM_W-1:0]  row_ff, row_in;
   logic [ROWB_W-1:0] rbc_ff, rbc_in;
   logic              fin_ff, fin_in;

   // Counter values after a start-of-image clear.
   logic [1:0]        bip_s;
   logic [23:0]       asm_s;
   logic [DIM_W-1:0]  col_s;
   logic [DIM_W-1:0]  row_s;
   logic [ROWB_W-1:0] rbc_s;
   logic              fin_s;

   logic [DIM_W-1:0]  w;
   logic [DIM_W-1:0]  h;
   logic [ROWB_W-1:0] data_bytes;
   logic [ROWB_W:0]   pad_row_bytes;
   logic [ROWB_W:0]   rbc_inc;
   logic              done_now;
   logic              in_data;
   logic              emit;
   logic              row_end;
   logic [1:0]        bpp_last;
   logic [DIM_W-1:0]  diff_x;
   logic [DIM_W-1:0]  diff_y;
   logic [DIM_W-1:0]  sx0;
   logic [DIM_W-1:0]  sy0;
   logic [DIM_W-1:0]  row_off;
   logic [DIM_W:0]    sx;
   logic [DIM_W:0]    sy;
   logic              visible;
   logic [BYTE_W-1:0] alpha;

   // Clamp the image size to the supported range.
   always_comb begin
      if (cfg.image_width == '0) begin
         w = DIM_W'(1);
      end else if ({1'b0, cfg.image_width} > MAX_W_EXT) begin
         w = MAX_W_EXT[DIM_W-1:0];
      end else begin
         w = cfg.image_width;
      end
      if (cfg.image_height == '0) begin
         h = DIM_W'(1);
      end else if ({1'b0, cfg.image_height} > MAX_H_EXT) begin
         h = MAX_H_EXT[DIM_W-1:0];
      end else begin
         h = cfg.image_height;
      end
   end

   // Row geometry: pixel bytes per row and the row size padded to a multiple of four bytes.
   assign bpp_last      = cfg.four_byte_pixels ? 2'd3 : 2'd2;
   assign data_bytes    = cfg.four_byte_pixels ? {w, 2'b00}
                                               : ({2'b00, w} + {1'b0, w, 1'b0});
   assign pad_row_bytes = ({1'b0, data_bytes} + (ROWB_W+1)'(3)) & ~(ROWB_W+1)'(3);

   // A start-of-image beat clears every counter before it is used.
   always_comb begin
      if (start_of_image) begin
         bip_s = '0;
         asm_s = '0;
         col_s = '0;
         row_s = '0;
         rbc_s = '0;
         fin_s = 1'b0;
      end else begin
         bip_s = bip_ff;
         asm_s = asm_ff;
         col_s = col_ff;
         row_s = row_ff;
         rbc_s = rbc_ff;
         fin_s = fin_ff;
      end
   end

   assign done_now = fin_s || (row_s >= h);
   assign in_data  = {1'b0, rbc_s} < {1'b0, data_bytes};
   assign emit     = bip_s >= bpp_last;
   assign rbc_inc  = {1'b0, rbc_s} + (ROWB_W+1)'(1);
   assign row_end  = rbc_inc >= pad_row_bytes;

   // Screen position: centered, start clamped at zero, rows flipped if needed.
   assign diff_x  = cfg.screen_width - w;
   assign diff_y  = cfg.screen_height - h;
   assign sx0     = (cfg.screen_width > w) ? (diff_x >> 1) : '0;
   assign sy0     = (cfg.screen_height > h) ? (diff_y >> 1) : '0;
   assign row_off = cfg.bottom_up ? (h - DIM_W'(1) - row_s) : row_s;
   assign sx      = {1'b0, sx0} + {1'b0, col_s};
   assign sy      = {1'b0, sy0} + {1'b0, row_off};
   assign visible = (sx < {1'b0, cfg.screen_width}) && (sy < {1'b0, cfg.screen_height});

   assign alpha = cfg.four_byte_pixels ? pixel_byte : OPAQUE_ALPHA;

   // Next counter state for an accepted beat.
   always_comb begin
      bip_in = bip_s;
      asm_in = asm_s;
      col_in = col_s;
      row_in = row_s;
      rbc_in = rbc_s;
      fin_in = fin_s;
      if (done_now) begin
         fin_in = 1'b1;
      end else begin
         if (in_data) begin
            case (bip_s)
               2'd0:    asm_in[7:0]   = pixel_byte;
               2'd1:    asm_in[15:8]  = pixel_byte;
               2'd2:    asm_in[23:16] = pixel_byte;
               default: asm_in        = asm_s;
            endcase
            if (emit) begin
               col_in = col_s + DIM_W'(1);
               bip_in = '0;
            end else begin
               bip_in = bip_s + 2'd1;
            end
         end
         rbc_in = rbc_inc[ROWB_W-1:0];
         if (row_end) begin
            rbc_in = '0;
            col_in = '0;
            bip_in = '0;
            row_in = row_s + DIM_W'(1);
            fin_in = (row_s + DIM_W'(1)) >= h;
         end
      end
   end

   // A finished pixel that lands on the screen.
   assign hit       = !done_now && in_data && emit && visible;
   assign pix.sx    = sx[DIM_W-1:0];
   assign pix.sy    = sy[DIM_W-1:0];
   assign pix.color = {alpha, asm_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         bip_ff <= '0;
         asm_ff <= '0;
         col_ff <= '0;
         row_ff <= '0;
         rbc_ff <= '0;
         fin_ff <= 1'b0;
      end else if (accept) begin
         bip_ff <= bip_in;
         asm_ff <= asm_in;
         col_ff <= col_in;
         row_ff <= row_in;
         rbc_ff <= rbc_in;
         fin_ff <= fin_in;
      end
   end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps

import bmprb_pkg::*;

// Tracks the blitter's scan state and configuration, predicts the framebuffer
// writes that each accepted byte causes and checks the response beats in order.
class blit_scoreboard;
   typedef struct packed {
      logic [OFFSET_W-1:0] offset;
      logic [COLOR_W-1:0]  color;
   } fb_write_type;

   // Copies of the configuration registers.
   logic [DIM_W-1:0]   img_w, img_h, scr_w, scr_h;
   logic               flip_rows, argb32;
   logic [PITCH_W-1:0] pitch;

   // Scan counters of the current image.
   logic [1:0]        byte_pos;
   logic [23:0]       assembly;
   logic [DIM_W-1:0]  col, row;
   logic [ROWB_W-1:0] row_bytes;
   logic              done;

   fb_write_type writes_q[$];
   int unsigned  errors, checked, clipped;

   function new();
      img_w     = RST_IMAGE_WIDTH;
      img_h     = RST_IMAGE_HEIGHT;
      flip_rows = RST_BOTTOM_UP;
      argb32    = RST_FOUR_BYTE;
      scr_w     = RST_SCREEN_WIDTH;
      scr_h     = RST_SCREEN_HEIGHT;
      pitch     = RST_SCREEN_PITCH;
      clear_scan();
      errors  = 0;
      checked = 0;
      clipped = 0;
   endfunction

   function void clear_scan();
      byte_pos  = '0;
      assembly  = '0;
      col       = '0;
      row       = '0;
      row_bytes = '0;
      done      = 1'b0;
   endfunction

   function void set_register(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_IMAGE_WIDTH:      img_w     = value[DIM_W-1:0];
         CSR_IMAGE_HEIGHT:     img_h     = value[DIM_W-1:0];
         CSR_BOTTOM_UP:        flip_rows = value[0];
         CSR_FOUR_BYTE_PIXELS: argb32    = value[0];
         CSR_SCREEN_WIDTH:     scr_w     = value[DIM_W-1:0];
         CSR_SCREEN_HEIGHT:    scr_h     = value[DIM_W-1:0];
         CSR_SCREEN_PITCH:     pitch     = value[PITCH_W-1:0];
         default: ;
      endcase
   endfunction

   // A zero size counts as one pixel, and sizes above the limit are cut to it.
   function int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned lim);
      if (v == 0) return 1;
      if (v > lim) return lim;
      return v;
   endfunction

   function int unsigned rows();
      return clamp_dim(img_h, DEF_MAX_HEIGHT);
   endfunction

   // Stored row length in bytes, padded up to a multiple of four.
   function int unsigned padded_row();
      int unsigned data_bytes;
      data_bytes = clamp_dim(img_w, DEF_MAX_WIDTH) * (argb32 ? 4 : 3);
      return (data_bytes + 3) & ~32'd3;
   endfunction

   // Advances the scan by one accepted byte. Returns 0 when the byte is ignored
   // because the image is already complete.
   function bit note_byte(logic [BYTE_W-1:0] value, logic sof);
      int unsigned  w, h, bpp, data_bytes, x0, y0, sx, sy, next_count;
      logic [31:0]  offset;
      fb_write_type wr;
      w          = clamp_dim(img_w, DEF_MAX_WIDTH);
      h          = rows();
      bpp        = argb32 ? 4 : 3;
      data_bytes = w * bpp;
      if (sof) clear_scan();
      if (!done && row >= h) done = 1'b1;
      if (done) return 1'b0;

      // Pixel data; bytes past the data of a row are padding.
      if (row_bytes < data_bytes) begin
         if (byte_pos < 3) assembly[8*byte_pos +: 8] = value;
         if (byte_pos >= bpp - 1) begin
            x0 = scr_w > w ? (scr_w - w) / 2 : 0;
            y0 = scr_h > h ? (scr_h - h) / 2 : 0;
            sx = x0 + col;
            sy = y0 + (flip_rows ? h - 1 - row : row);
            if (sx < scr_w && sy < scr_h) begin
               offset    = sy * pitch + sx * 4;
               wr.offset = offset[OFFSET_W-1:0];
               wr.color  = {argb32 ? value : OPAQUE_ALPHA, assembly};
               writes_q.push_back(wr);
            end else begin
               clipped++;
            end
            col      = col + 1'b1;
            byte_pos = '0;
         end else begin
            byte_pos = byte_pos + 1'b1;
         end
      end

      // End of a stored row, and of the image after its last row.
      next_count = row_bytes + 1;
      if (next_count >= padded_row()) begin
         row_bytes = '0;
         col       = '0;
         byte_pos  = '0;
         row       = row + 1'b1;
         if (row >= h) done = 1'b1;
      end else begin
         row_bytes = next_count[ROWB_W-1:0];
      end
      return 1'b1;
   endfunction

   function void check_pixel(logic [OFFSET_W-1:0] offset, logic [COLOR_W-1:0] color);
      fb_write_type want;
      if (writes_q.size() == 0) begin
         $error("Pixel write with none expected: fb_byte_offset %h, argb_color %h",
                offset, color);
         errors++;
         return;
      end
      want = writes_q.pop_front();
      checked++;
      if (offset !== want.offset) begin
         $error("fb_byte_offset: expected %h, actual %h", want.offset, offset);
         errors++;
      end
      if (color !== want.color) begin
         $error("argb_color: expected %h, actual %h", want.color, color);
         errors++;
      end
   endfunction
endclass

module tb_top;
   localparam int RANDOM_BYTES = 950;
   localparam int QUIET_TAIL   = 150;
   localparam int DRAIN_CYCLES = 6;
   localparam int TIMEOUT_NS   = 4_000_000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [BYTE_W-1:0]      req_pixel_byte = '0;
   logic                   req_start_of_image = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [OFFSET_W-1:0]    rsp_fb_byte_offset;
   logic [COLOR_W-1:0]     rsp_argb_color;

   bit          calm = 1'b0;
   bit          valid_up = 1'b0;
   int unsigned bytes_used = 0;
   int unsigned setups = 0;

   blit_scoreboard sb = new();

   bmp_row_blit_to_framebuffer dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_pixel_byte     (req_pixel_byte),
      .req_start_of_image (req_start_of_image),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_fb_byte_offset (rsp_fb_byte_offset),
      .rsp_argb_color     (rsp_argb_color)
   );

   always #6 clock = ~clock;

   // Every response beat is checked against the oldest predicted write.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_pixel(rsp_fb_byte_offset, rsp_argb_color);
   end

   // Response back-pressure in random bursts; none once the run goes quiet.
   initial begin : rsp_backpressure
      int unsigned burst;
      forever begin
         @(posedge clock);
         burst = $urandom_range(1, 15);
         rsp_stall <= !calm && ($urandom_range(0, 2) == 0);
         repeat (burst - 1) @(posedge clock);
      end
   end

   initial begin : watchdog
      #TIMEOUT_NS;
      $display("tb_top NOT OK");
      $finish;
   end

   // Sends one byte beat, sometimes after an idle burst, and waits for it to be taken.
   task automatic send_byte(logic [BYTE_W-1:0] value, logic sof);
      int unsigned gap;
      if (!calm && $urandom_range(0, 6) == 0) begin
         gap = $urandom_range(1, 15);
         if (valid_up) begin
            req_valid <= 1'b0;
            valid_up = 1'b0;
         end
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      valid_up = 1'b1;
      req_pixel_byte     <= value;
      req_start_of_image <= sof;
      do @(posedge clock); while (req_stall);
      if (sb.note_byte(value, sof)) bytes_used++;
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      sb.set_register(idx, value);
   endtask

   task automatic program_image(int unsigned iw, int unsigned ih, int unsigned bu,
                                int unsigned fb, int unsigned sw, int unsigned sh,
                                int unsigned sp);
      write_reg(CSR_IMAGE_WIDTH, 15'(iw));
      write_reg(CSR_IMAGE_HEIGHT, 15'(ih));
      write_reg(CSR_BOTTOM_UP, 15'(bu));
      write_reg(CSR_FOUR_BYTE_PIXELS, 15'(fb));
      write_reg(CSR_SCREEN_WIDTH, 15'(sw));
      write_reg(CSR_SCREEN_HEIGHT, 15'(sh));
      write_reg(CSR_SCREEN_PITCH, 15'(sp));
      csr_write_en <= 1'b0;
      setups++;
   endtask

   // Stops the byte stream and waits for the pipeline to empty.
   task automatic settle();
      if (valid_up) begin
         req_valid <= 1'b0;
         valid_up = 1'b0;
      end
      while (sb.writes_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Mostly small sizes, with zero, the clamp limit and the 13-bit maximum now and then.
   function automatic logic [CSR_DATA_W-1:0] pick_dim(int unsigned usual);
      int unsigned r;
      r = $urandom_range(0, 31);
      if (r == 0) return '0;
      if (r == 1) return 15'd8191;
      if (r == 2) return 15'd4096;
      if (r == 3) return 15'($urandom_range(0, 8191));
      return 15'($urandom_range(1, usual));
   endfunction

   initial begin : stimulus
      int unsigned n, k, cap, target, iw, ih, sw, sh, sp, r;
      logic        fresh;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset configuration: one 24-bit pixel, its padding, then a byte past the end.
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h5A, 1'b0);
      send_byte(8'hA5, 1'b0);
      settle();

      // Oversized image clamped on both axes; the offset wraps past 26 bits.
      program_image(8191, 8191, 1, 1, 8191, 8191, 32767);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h01, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'h00, 1'b0);
      settle();

      // Zero image size counts as one pixel; a zero screen width clips it.
      program_image(0, 0, 1, 0, 0, 4, 16);
      for (k = 0; k < 4; k++) send_byte(8'($urandom_range(0, 255)), k == 0);
      settle();

      // Image wider than the screen with a zero pitch: both rows land at offset zero.
      program_image(2, 2, 1, 0, 1, 2, 0);
      for (k = 0; k < 16; k++) send_byte(8'($urandom_range(0, 255)), k == 0);

      // Random images, mostly complete and well formed, some cut short or restarted,
      // and some that carry on after a configuration change mid-image.
      target = bytes_used + RANDOM_BYTES;
      while (bytes_used < target) begin
         calm = bytes_used + QUIET_TAIL >= target;
         settle();
         fresh = $urandom_range(0, 7) != 0;
         if (fresh) begin
            iw = pick_dim(10);
            ih = pick_dim(5);
            sw = pick_dim(24);
            sh = pick_dim(24);
            r  = $urandom_range(0, 15);
            if (r == 0) sp = 0;
            else if (r == 1) sp = 32767;
            else if (r == 2) sp = $urandom_range(0, 32767);
            else sp = (sw * 4 + 4 * $urandom_range(0, 3)) & 32'h7FFF;
            program_image(iw, ih, $urandom_range(0, 1), $urandom_range(0, 1), sw, sh, sp);
            cap = $urandom_range(24, 160);
            n   = sb.padded_row() * sb.rows();
            if (n > cap) n = cap;
         end else begin
            repeat ($urandom_range(1, 3)) begin
               write_reg(csr_index_type'($urandom_range(0, 6)), pick_dim(12));
            end
            csr_write_en <= 1'b0;
            n = $urandom_range(8, 60);
         end
         for (k = 0; k < n; k++) begin
            send_byte(8'($urandom_range(0, 255)),
                      (k == 0 && fresh) || $urandom_range(0, 79) == 0);
         end
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0);
         end
      end
      settle();

      $display("Streamed %0d pixel bytes over %0d image setups plus mid-image changes.",
               bytes_used, setups);
      $display("Checked %0d framebuffer writes; %0d pixels were clipped off screen.",
               sb.checked, sb.clipped);
      if (sb.errors == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end
endmodule

// File: filelist.f
sv/bmprb_pkg.sv
sv/bmprb_scan.sv
sv/bmp_row_blit_to_framebuffer.sv
dv/tb_top.sv
